@@ design/usd_pkg.sv @@
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants of the utf-8 stream decoder
// item kinds between front and back, error codes and queue sizing
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = 1;
    localparam int unsigned QCNT_W  = 2;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
    localparam logic [CP_W-1:0] MAX_ONE_BYTE   = 21'h00007F;
    localparam logic [CP_W-1:0] MAX_TWO_BYTE   = 21'h0007FF;
    localparam logic [CP_W-1:0] MAX_THREE_BYTE = 21'h00FFFF;
    localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_CONT = 3'd1,
        ERR_OVERLONG = 3'd2,
        ERR_RANGE    = 3'd3,
        ERR_BAD_LEAD = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        KIND_DIRECT   = 2'd0,
        KIND_BAD_LEAD = 2'd1,
        KIND_TRUNC    = 2'd2,
        KIND_FINISH   = 2'd3
    } t_kind;

    // continuation byte counts of a sequence
    localparam logic [1:0] LEN_TWO   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;
    localparam logic [1:0] LEN_FOUR  = 2'd3;

    typedef struct packed {
        t_kind           kind;
        logic [CP_W-1:0] value;
        logic [1:0]      seq_len;
        logic            cont_bad;
        logic            stream_end;
    } t_item;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

@@ design/usd_if.sv @@
// ----------------------------------------------------------------------------
// usd_if: request channels of the utf-8 stream decoder
// byte channel in, code point channel out, valid/ready handshake
// ----------------------------------------------------------------------------
interface usd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface usd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  error_code;
    logic        stream_end;

    modport source (output valid, output code_point, output error_code,
                    output stream_end, input ready);
    modport sink   (input valid, input code_point, input error_code,
                    input stream_end, output ready);
endinterface

@@ design/usd_front.sv @@
// ----------------------------------------------------------------------------
// usd_front: byte intake of the utf-8 stream decoder
// tracks the open sequence, gathers payload bits, posts finished items
// ----------------------------------------------------------------------------
module usd_front
    import usd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    usd_in_if.sink     i_in,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_item      o_item
);

    logic [1:0]      r_remaining, n_remaining;
    logic [1:0]      r_seq_len,   n_seq_len;
    logic [CP_W-1:0] r_acc,       n_acc;
    logic            r_bad,       n_bad;

    logic       accept;
    logic [7:0] b;
    logic       eos;
    logic [1:0] left;
    logic       bad_now;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign eos        = i_in.end_of_stream;
    assign left       = r_remaining - 2'd1;
    assign bad_now    = r_bad || (b[7:6] != 2'b10);

    always_comb begin
        n_remaining = r_remaining;
        n_seq_len   = r_seq_len;
        n_acc       = r_acc;
        n_bad       = r_bad;
        o_push      = 1'b0;
        o_item      = '{kind: KIND_DIRECT, value: {13'd0, b}, seq_len: r_seq_len,
                        cont_bad: bad_now, stream_end: eos};
        if (accept) begin
            if (r_remaining == 2'd0) begin
                if (!b[7]) begin
                    o_push = 1'b1;
                end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 ||
                             b[7:3] == 5'b11110) begin
                    if (eos) begin
                        // lead byte as last byte: cut-off sequence
                        o_push      = 1'b1;
                        o_item.kind = KIND_TRUNC;
                    end else begin
                        n_bad = 1'b0;
                        if (b[7:5] == 3'b110) begin
                            n_remaining = LEN_TWO;
                            n_acc       = {16'd0, b[4:0]};
                        end else if (b[7:4] == 4'b1110) begin
                            n_remaining = LEN_THREE;
                            n_acc       = {17'd0, b[3:0]};
                        end else begin
                            n_remaining = LEN_FOUR;
                            n_acc       = {18'd0, b[2:0]};
                        end
                        n_seq_len = n_remaining;
                    end
                end else begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_BAD_LEAD;
                end
            end else begin
                o_item.value = {r_acc[CP_W-7:0], b[5:0]};
                if (left == 2'd0) begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_FINISH;
                    n_remaining = 2'd0;
                    n_seq_len   = 2'd0;
                    n_acc       = '0;
                    n_bad       = 1'b0;
                end else if (eos) begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_TRUNC;
                    n_remaining = 2'd0;
                    n_seq_len   = 2'd0;
                    n_acc       = '0;
                    n_bad       = 1'b0;
                end else begin
                    n_remaining = left;
                    n_acc       = {r_acc[CP_W-7:0], b[5:0]};
                    n_bad       = bad_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 2'd0;
            r_seq_len   <= 2'd0;
            r_acc       <= '0;
            r_bad       <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_seq_len   <= n_seq_len;
            r_acc       <= n_acc;
            r_bad       <= n_bad;
        end
    end

endmodule

@@ design/usd_queue.sv @@
// ----------------------------------------------------------------------------
// usd_queue: short item queue between front and back
// while not full, push and pop in the same cycle keep full rate
// ----------------------------------------------------------------------------
module usd_queue
    import usd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_item      i_item,
    input  logic       i_pop,
    output t_q_status  o_status,
    output t_item      o_head
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_status.full      = (r_count == QCNT_W'(QDEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign do_push            = i_push && !o_status.full;
    assign do_pop             = i_pop && o_status.not_empty;
    assign o_head             = r_mem[r_rd];

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ design/usd_back.sv @@
// ----------------------------------------------------------------------------
// usd_back: result stage of the utf-8 stream decoder
// range and form checks, error coding, output register
// ----------------------------------------------------------------------------
module usd_back
    import usd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_item      i_head,
    output logic       o_pop,
    usd_out_if.source  o_out
);

    logic            r_valid, n_valid;
    logic [CP_W-1:0] r_cp;
    t_err            r_err;
    logic            r_end;
    t_err            err;
    logic [CP_W-1:0] v;

    assign v     = i_head.value;
    assign o_pop = i_q_status.not_empty && (!r_valid || o_out.ready);

    always_comb begin
        err = ERR_NONE;
        case (i_head.kind)
            KIND_DIRECT:   err = ERR_NONE;
            KIND_BAD_LEAD: err = ERR_BAD_LEAD;
            KIND_TRUNC:    err = ERR_BAD_CONT;
            KIND_FINISH: begin
                if (i_head.cont_bad) begin
                    err = ERR_BAD_CONT;
                end else begin
                    case (i_head.seq_len)
                        LEN_TWO: begin
                            if (v <= MAX_ONE_BYTE) err = ERR_OVERLONG;
                        end
                        LEN_THREE: begin
                            if (v <= MAX_TWO_BYTE) err = ERR_OVERLONG;
                            else if (v inside {[SURR_LO:SURR_HI]}) err = ERR_RANGE;
                        end
                        LEN_FOUR: begin
                            if (v <= MAX_THREE_BYTE) err = ERR_OVERLONG;
                            else if (v > MAX_SCALAR) err = ERR_RANGE;
                        end
                        default: err = ERR_NONE;
                    endcase
                end
            end
            default: err = ERR_NONE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cp  <= (err == ERR_NONE) ? v : REPLACEMENT_CP;
            r_err <= err;
            r_end <= i_head.stream_end;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.code_point = r_cp;
    assign o_out.error_code = r_err;
    assign o_out.stream_end = r_end;

endmodule

@@ design/utf8_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top: streaming utf-8 to code point decoder
// Takes one byte per request and returns one code point request per finished
// sequence (one to four bytes), U+FFFD with an error code on bad sequences
// ----------------------------------------------------------------------------
// The decoder sustains one byte per clock cycle while the queue has room: the
// byte front end holds the open sequence state, and a result leaves the back
// end through its output register. A result passes the queue entry and then
// the output register before it shows on the output.
// The two-entry queue between front and back absorbs output stalls; input
// ready drops only once that queue is full, so a stalled sink costs no bytes
// and no results. Error codes: 1 bad continuation (also a stream that ends
// inside a sequence), 2 overlong, 3 surrogate or above U+10FFFF, 4 bad lead.
// Bytes that only open or extend a sequence give no result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
    import usd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    usd_in_if.sink     i_in,
    usd_out_if.source  o_out
);

    // front to queue
    logic      push;
    t_item     item;
    // queue to back
    logic      pop;
    t_item     head;
    t_q_status q_status;

    // byte intake and sequence tracking
    usd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (item)
    );

    // decoupling queue
    usd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (item),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head)
    );

    // checks, error coding and output register
    usd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

@@ design/usd_checker.sv @@
// ----------------------------------------------------------------------------
// usd_checker: port level checks of the utf-8 stream decoder
// result consistency and output handshake behavior
// ----------------------------------------------------------------------------
module usd_checker
    import usd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_code_point,
    input logic [2:0]  i_error_code
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point))
        else $error("stalled result changed");

    // error results carry the replacement character
    a_err_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error_code != ERR_NONE |-> i_code_point == REPLACEMENT_CP)
        else $error("error without replacement character");

    // error codes stay in range
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_error_code <= ERR_BAD_LEAD)
        else $error("unknown error code");

    // clean results are scalar values
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error_code == ERR_NONE |->
            i_code_point <= MAX_SCALAR &&
            (i_code_point < SURR_LO || i_code_point > SURR_HI))
        else $error("clean result is not a scalar value");

endmodule

bind utf8_stream_decoder_top usd_checker u_usd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_code_point (o_out.code_point),
    .i_error_code (o_out.error_code)
);

@@ dv/utf8_stream_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb: self-checking bench of the utf-8 stream decoder
// Sends directed and random byte streams with random gaps on both channels,
// predicts every code point request and checks each one as it leaves.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;
    import usd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int RANDOM_ITEMS     = 1000;
    // long output stall of the backpressure test
    localparam int SINK_HOLD_CYCLES = 300;
    // a correct run never goes this long without a request on either side:
    // the longest stall is the sink hold above, random gaps stay shorter than it
    localparam int STALL_LIMIT      = 3000;
    // tail after the drain, past the queue and the output register
    localparam int TAIL_CYCLES      = 8;

    // one predicted code point request
    typedef struct packed {
        logic [20:0] code_point;
        t_err        error_code;
        logic        stream_end;
    } t_cp_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    usd_in_if  in_ch ();
    usd_out_if out_ch ();

    utf8_stream_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // decoder state as predicted from accepted bytes
    logic [1:0]  pred_cont_left = 2'd0;
    logic [1:0]  pred_seq_len   = 2'd0;
    logic [20:0] pred_payload   = 21'd0;
    logic        pred_cont_bad  = 1'b0;

    t_cp_result expected_code_points[$];

    int   n_fail         = 0;
    int   bytes_accepted = 0;
    int   idle_cycles    = 0;
    // percent of requests preceded by a gap, per side
    int   src_idle_pct   = 30;
    int   snk_idle_pct   = 30;
    logic hold_sink      = 1'b0;

    // ------------------------------------------------------------------------
    // gap lengths: mostly none or short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input int pct);
        int r;
        if ($urandom_range(0, 99) >= pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // code point prediction
    // ------------------------------------------------------------------------
    function automatic void push_expected(input logic [20:0] cp, input t_err err,
                                          input logic eos);
        t_cp_result r;
        r.code_point = cp;
        r.error_code = err;
        r.stream_end = eos;
        expected_code_points.push_back(r);
    endfunction

    function automatic void clear_open_sequence();
        pred_cont_left = 2'd0;
        pred_seq_len   = 2'd0;
        pred_payload   = 21'd0;
        pred_cont_bad  = 1'b0;
    endfunction

    function automatic void predict_code_point(input logic [7:0] b, input logic eos);
        logic [1:0]  need;
        logic [20:0] lead_bits;
        t_err        err;
        need      = 2'd0;
        lead_bits = 21'd0;
        err       = ERR_NONE;

        // no open sequence: this byte is a lead
        if (pred_cont_left == 2'd0) begin
            if (!b[7]) begin
                push_expected({13'd0, b}, ERR_NONE, eos);
                return;
            end
            if (b[7:5] == 3'b110) begin
                need      = LEN_TWO;
                lead_bits = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                need      = LEN_THREE;
                lead_bits = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                need      = LEN_FOUR;
                lead_bits = {18'd0, b[2:0]};
            end else begin
                push_expected(REPLACEMENT_CP, ERR_BAD_LEAD, eos);
                return;
            end
            // stream ends on a lead byte: truncated sequence
            if (eos) begin
                clear_open_sequence();
                push_expected(REPLACEMENT_CP, ERR_BAD_CONT, 1'b1);
                return;
            end
            pred_cont_left = need;
            pred_seq_len   = need;
            pred_payload   = lead_bits;
            pred_cont_bad  = 1'b0;
            return;
        end

        // continuation byte, consumed whatever it holds
        if (b[7:6] != 2'b10) pred_cont_bad = 1'b1;
        pred_payload   = {pred_payload[14:0], b[5:0]};
        pred_cont_left = pred_cont_left - 2'd1;

        if (pred_cont_left == 2'd0) begin
            // bad continuation wins over overlong and range errors
            if (pred_cont_bad) begin
                err = ERR_BAD_CONT;
            end else if (pred_seq_len == LEN_TWO) begin
                if (pred_payload <= MAX_ONE_BYTE) err = ERR_OVERLONG;
            end else if (pred_seq_len == LEN_THREE) begin
                if (pred_payload <= MAX_TWO_BYTE) err = ERR_OVERLONG;
                else if (pred_payload >= SURR_LO && pred_payload <= SURR_HI) err = ERR_RANGE;
            end else begin
                if (pred_payload <= MAX_THREE_BYTE) err = ERR_OVERLONG;
                else if (pred_payload > MAX_SCALAR) err = ERR_RANGE;
            end
            push_expected((err == ERR_NONE) ? pred_payload : REPLACEMENT_CP, err, eos);
            clear_open_sequence();
        end else if (eos) begin
            // stream ends inside a sequence: drop what was gathered
            clear_open_sequence();
            push_expected(REPLACEMENT_CP, ERR_BAD_CONT, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // byte sender: optional gap, then hold the request until accepted
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_accepted++;
        predict_code_point(b, eos);
    endtask

    // up to four bytes, left aligned, first byte in the top octet
    task automatic send_sequence(input logic [31:0] seq, input int n, input logic eos_last);
        int k;
        for (k = 0; k < n; k++)
            send_byte(seq[31 - 8 * k -: 8], eos_last && (k == n - 1));
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // well-formed encoding of a payload in n bytes, no range check
    function automatic logic [31:0] encode_scalar(input logic [20:0] v, input int n);
        case (n)
            1: return {1'b0, v[6:0], 24'd0};
            2: return {3'b110, v[10:6], 2'b10, v[5:0], 16'd0};
            3: return {4'b1110, v[15:12], 2'b10, v[11:6], 2'b10, v[5:0], 8'd0};
            default: return {5'b11110, v[20:18], 2'b10, v[17:12], 2'b10, v[11:6],
                             2'b10, v[5:0]};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------
    task automatic test_ascii();
        send_sequence(32'h0000_0000, 1, 1'b0);
        // stream end on a plain byte
        send_sequence(32'h7F00_0000, 1, 1'b1);
    endtask

    task automatic test_multibyte_scalars();
        send_sequence(32'hDFBF_0000, 2, 1'b0);  // U+07FF
        send_sequence(32'hF48F_BFBF, 4, 1'b0);  // U+10FFFF
    endtask

    task automatic test_bad_lead();
        send_sequence(32'h8000_0000, 1, 1'b0);  // stray continuation as lead
        send_sequence(32'hFF00_0000, 1, 1'b1);  // top lead with stream end
    endtask

    task automatic test_overlong_and_range();
        send_sequence(32'hC1BF_0000, 2, 1'b0);  // C1 lead, always overlong
        send_sequence(32'hE09F_BF00, 3, 1'b0);  // three bytes for U+07FF
        send_sequence(32'hEDA0_8000, 3, 1'b0);  // surrogate
        send_sequence(32'hF490_8080, 4, 1'b0);  // above U+10FFFF
    endtask

    task automatic test_bad_continuation();
        // ascii in a continuation slot is still eaten by the sequence
        send_sequence(32'hC241_0000, 2, 1'b0);
    endtask

    task automatic test_truncated_stream();
        send_sequence(32'hE200_0000, 1, 1'b1);  // ends on the lead
        send_sequence(32'hF090_0000, 2, 1'b1);  // ends mid sequence
    endtask

    // sink holds off long while bytes keep coming, so the input must stall
    task automatic test_output_backpressure();
        int k;
        src_idle_pct = 0;
        hold_sink    = 1'b1;
        for (k = 0; k < 24; k++) begin
            if (k % 4 == 3)
                send_sequence(encode_scalar(21'($urandom_range(21'h80, 21'h7FF)), 2), 2, 1'b0);
            else
                send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        end
        src_idle_pct = 30;
    endtask

    task automatic test_random_stream();
        int          start_count;
        int          next_mix;
        int          r;
        int          n;
        int          pos;
        logic [20:0] v;
        logic [31:0] seq;
        logic        eos_last;
        start_count = bytes_accepted;
        next_mix    = bytes_accepted;
        while (bytes_accepted - start_count < RANDOM_ITEMS) begin
            // change the idling mix now and then, with quiet stretches too
            if (bytes_accepted >= next_mix) begin
                case ($urandom_range(0, 2))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 20;
                    default: src_idle_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0: snk_idle_pct = 0;
                    1: snk_idle_pct = 20;
                    default: snk_idle_pct = 50;
                endcase
                next_mix = bytes_accepted + 100;
            end

            r        = $urandom_range(0, 99);
            n        = $urandom_range(1, 4);
            eos_last = ($urandom_range(0, 99) < 4);

            // payload: mostly a legal scalar of that length, else anything
            if (n == 1) begin
                v = 21'($urandom_range(0, 21'h7F));
            end else if (r < 45 || r >= 60) begin
                case (n)
                    2: v = 21'($urandom_range(21'h80, 21'h7FF));
                    3: v = 21'($urandom_range(21'h800, 21'hFFFF));
                    default: v = 21'($urandom_range(21'h10000, 21'h10FFFF));
                endcase
            end else if (n == 3 && $urandom_range(0, 1) == 1) begin
                v = 21'($urandom_range(21'hD800, 21'hDFFF));
            end else begin
                v = 21'($urandom_range(0, (1 << (5 * n + 1)) - 1));
            end
            seq = encode_scalar(v, n);

            if (r >= 60 && r < 72 && n > 1) begin
                // one continuation replaced by a random byte
                pos = $urandom_range(1, n - 1);
                seq[31 - 8 * pos -: 8] = 8'($urandom_range(0, 255));
            end else if (r >= 72 && r < 82 && n > 1) begin
                // cut short by the end of the stream
                n        = $urandom_range(1, n - 1);
                eos_last = 1'b1;
            end else if (r >= 82) begin
                // raw noise
                seq = $urandom();
            end
            send_sequence(seq, n, eos_last);
        end
    endtask

    // ------------------------------------------------------------------------
    // output ready: random stalls, or one long hold when asked
    // ------------------------------------------------------------------------
    initial begin : sink_ready
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                hold_sink = 1'b0;
            end else begin
                stall = pick_gap(snk_idle_pct);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted request against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_cp_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_code_points.size() == 0) begin
                $error("unexpected result: code_point %h error_code %0d stream_end %b",
                       out_ch.code_point, out_ch.error_code, out_ch.stream_end);
                n_fail++;
            end else begin
                want = expected_code_points.pop_front();
                if (out_ch.code_point !== want.code_point) begin
                    $error("code_point: expected %h, actual %h",
                           want.code_point, out_ch.code_point);
                    n_fail++;
                end
                if (out_ch.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, actual %0d",
                           want.error_code, out_ch.error_code);
                    n_fail++;
                end
                if (out_ch.stream_end !== want.stream_end) begin
                    $error("stream_end: expected %b, actual %b",
                           want.stream_end, out_ch.stream_end);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long with no request on either channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("utf8_stream_decoder_top_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= 8'd0;
        in_ch.end_of_stream <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ascii();
        test_multibyte_scalars();
        test_bad_lead();
        test_overlong_and_range();
        test_bad_continuation();
        test_truncated_stream();
        test_output_backpressure();
        test_random_stream();
        release_input();

        // drain, then a short tail to catch stray results
        while (expected_code_points.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_fail == 0 && expected_code_points.size() == 0)
            $display("utf8_stream_decoder_top_tb OK");
        else
            $display("utf8_stream_decoder_top_tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
design/usd_pkg.sv
design/usd_if.sv
design/usd_front.sv
design/usd_queue.sv
design/usd_back.sv
design/utf8_stream_decoder_top.sv
design/usd_checker.sv
dv/utf8_stream_decoder_top_tb.sv
